// ===== rtl/core/wps_pkg.sv =====
// Shared types and constants for the wheel prime sieve.
package wps_pkg;

  localparam int WORD_BITS = 32;
  localparam int COL_W     = 5;
  localparam int PRIME_W   = 16;
  localparam int CFG_W     = 17;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd65536;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } seq_stat_t;

endpackage

// ===== rtl/core/wps_mem.sv =====
// Sieve bit memory, one word per row, one write port and one registered read port.
module wps_mem
  import wps_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int RW    = 11
) (
  input  logic                 clk,
  input  mem_ctl_t             ctl,
  input  logic [RW-1:0]        rd_addr,
  input  logic [RW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/wps_seq.sv =====
// Sequencer that clears the sieve memory on reset and on restart requests, and scans and marks it to answer requests.
module wps_seq
  import wps_pkg::*;
#(
  parameter int SIEVE_SIZE = 65536,
  parameter int CW         = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  logic               req_restart,
  input  logic [CW-1:0]      lim_in,
  input  logic               res_take,
  output seq_stat_t          stat,
  output logic [PRIME_W-1:0] res_prime,
  output logic               res_found
);

  localparam int AW    = $clog2(SIEVE_SIZE);
  localparam int RW    = AW - COL_W;
  localparam int DEPTH = (SIEVE_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int UW    = CW + 1;
  localparam int JW    = CW + 3;
  localparam int SW    = 2 * CW;

  localparam logic [RW-1:0] CLR_LAST   = RW'(DEPTH - 1);
  localparam logic [UW-1:0] FIRST_CAND = UW'(5);
  localparam logic [UW-1:0] STEP_TWO   = UW'(2);
  localparam logic [UW-1:0] STEP_FOUR  = UW'(4);

  localparam logic [1:0] STAGE_TWO   = 2'd0;
  localparam logic [1:0] STAGE_THREE = 2'd1;
  localparam logic [1:0] STAGE_SCAN  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_WT,
    S_SQ,
    S_MSTART,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [RW-1:0]        clr_addr_r, clr_addr_nxt;
  logic                 pend2_r, pend2_nxt;
  logic [1:0]           stage_r, stage_nxt;
  logic                 exhausted_r, exhausted_nxt;
  logic [UW-1:0]        cursor_r, cursor_nxt;
  logic                 phase_r, phase_nxt;
  logic [CW-1:0]        lim_r, lim_nxt;
  logic [CW-1:0]        cand_r, cand_nxt;
  logic                 a_r, a_nxt;
  logic [SW-1:0]        sq_r, sq_nxt;
  logic [JW-1:0]        j_r, j_nxt;
  logic                 cache_v_r, cache_v_nxt;
  logic [RW-1:0]        cache_row_r, cache_row_nxt;
  logic [WORD_BITS-1:0] cache_word_r, cache_word_nxt;
  logic [PRIME_W-1:0]   res_prime_r, res_prime_nxt;
  logic                 res_found_r, res_found_nxt;

  mem_ctl_t             mem_ctl;
  logic [RW-1:0]        rd_addr;
  logic [RW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_data;

  logic [RW-1:0]        cur_row;
  logic [RW-1:0]        j_row;
  logic                 cur_in_range;
  logic                 j_in_range;
  logic                 cache_hit;
  logic [JW-1:0]        p2;
  logic [JW-1:0]        p4;

  assign cur_row      = cursor_r[AW-1:COL_W];
  assign j_row        = j_r[AW-1:COL_W];
  assign cur_in_range = cursor_r < UW'(lim_r);
  assign j_in_range   = j_r < JW'(lim_r);
  assign cache_hit    = cache_v_r && (cache_row_r == cur_row);
  assign p2           = JW'(cand_r) << 1;
  assign p4           = JW'(cand_r) << 2;

  always_comb begin
    mem_ctl = '0;
    rd_addr = cur_row;
    wr_addr = j_row;
    wr_data = rd_data | (WORD_BITS'(1) << j_r[COL_W-1:0]);
    case (state_r)
      S_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_addr_r;
        wr_data       = '0;
      end
      S_SCAN: begin
        mem_ctl.rd_en = cur_in_range && !cache_hit;
      end
      S_MARK_RD: begin
        mem_ctl.rd_en = j_in_range;
        rd_addr       = j_row;
      end
      S_MARK_WR: begin
        mem_ctl.wr_en = 1'b1;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  wps_mem #(
    .DEPTH (DEPTH),
    .RW    (RW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    pend2_nxt      = pend2_r;
    stage_nxt      = stage_r;
    exhausted_nxt  = exhausted_r;
    cursor_nxt     = cursor_r;
    phase_nxt      = phase_r;
    lim_nxt        = lim_r;
    cand_nxt       = cand_r;
    a_nxt          = a_r;
    sq_nxt         = sq_r;
    j_nxt          = j_r;
    cache_v_nxt    = cache_v_r;
    cache_row_nxt  = cache_row_r;
    cache_word_nxt = cache_word_r;
    res_prime_nxt  = res_prime_r;
    res_found_nxt  = res_found_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + RW'(1);
        if (clr_addr_r == CLR_LAST) begin
          if (pend2_r) begin
            pend2_nxt     = 1'b0;
            res_prime_nxt = PRIME_W'(2);
            res_found_nxt = 1'b1;
            stage_nxt     = STAGE_THREE;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          lim_nxt = lim_in;
          if (req_restart) begin
            clr_addr_nxt  = '0;
            pend2_nxt     = 1'b1;
            stage_nxt     = STAGE_TWO;
            exhausted_nxt = 1'b0;
            cursor_nxt    = FIRST_CAND;
            phase_nxt     = 1'b1;
            cache_v_nxt   = 1'b0;
            state_nxt     = S_CLEAR;
          end else begin
            case (stage_r)
              STAGE_TWO: begin
                res_prime_nxt = PRIME_W'(2);
                res_found_nxt = 1'b1;
                stage_nxt     = STAGE_THREE;
                state_nxt     = S_DONE;
              end
              STAGE_THREE: begin
                res_prime_nxt = PRIME_W'(3);
                res_found_nxt = 1'b1;
                stage_nxt     = STAGE_SCAN;
                state_nxt     = S_DONE;
              end
              default: begin
                if (exhausted_r) begin
                  res_prime_nxt = '0;
                  res_found_nxt = 1'b0;
                  state_nxt     = S_DONE;
                end else begin
                  state_nxt = S_SCAN;
                end
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (!cur_in_range) begin
          exhausted_nxt = 1'b1;
          res_prime_nxt = '0;
          res_found_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else if (cache_hit) begin
          cursor_nxt = cursor_r + (phase_r ? STEP_TWO : STEP_FOUR);
          phase_nxt  = !phase_r;
          if (!cache_word_r[cursor_r[COL_W-1:0]]) begin
            cand_nxt  = CW'(cursor_r);
            a_nxt     = phase_r;
            state_nxt = S_SQ;
          end
        end else begin
          state_nxt = S_SCAN_WT;
        end
      end
      S_SCAN_WT: begin
        cache_word_nxt = rd_data;
        cache_row_nxt  = cur_row;
        cache_v_nxt    = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SQ: begin
        sq_nxt    = SW'(cand_r) * SW'(cand_r);
        state_nxt = S_MSTART;
      end
      S_MSTART: begin
        if (sq_r >= SW'(lim_r)) begin
          res_prime_nxt = PRIME_W'(cand_r);
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          j_nxt     = JW'(sq_r);
          state_nxt = S_MARK_RD;
        end
      end
      S_MARK_RD: begin
        if (!j_in_range) begin
          cache_v_nxt   = 1'b0;
          res_prime_nxt = PRIME_W'(cand_r);
          res_found_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        j_nxt     = j_r + (a_r ? p2 : p4);
        a_nxt     = !a_r;
        state_nxt = S_MARK_RD;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      pend2_r     <= 1'b0;
      stage_r     <= STAGE_TWO;
      exhausted_r <= 1'b0;
      cursor_r    <= FIRST_CAND;
      phase_r     <= 1'b1;
      cache_v_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend2_r     <= pend2_nxt;
      stage_r     <= stage_nxt;
      exhausted_r <= exhausted_nxt;
      cursor_r    <= cursor_nxt;
      phase_r     <= phase_nxt;
      cache_v_r   <= cache_v_nxt;
    end
    lim_r        <= lim_nxt;
    cand_r       <= cand_nxt;
    a_r          <= a_nxt;
    sq_r         <= sq_nxt;
    j_r          <= j_nxt;
    cache_row_r  <= cache_row_nxt;
    cache_word_r <= cache_word_nxt;
    res_prime_r  <= res_prime_nxt;
    res_found_r  <= res_found_nxt;
  end

  assign stat.busy      = (state_r != S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res_prime      = res_prime_r;
  assign res_found      = res_found_r;

endmodule

// ===== rtl/core/wheel_prime_sieve.sv =====
// Top level of the wheel prime sieve with limit register and output register.
// Each transaction on the input returns the next prime in ascending order,
// 2 and 3 first whatever the limit and then each prime below the limit, or
// found low once the sequence is exhausted. The sieve state sits in a
// memory of SIEVE_SIZE/32 rows of 32 bits, and all timing follows from its
// single read and single write port. After reset and after every restart
// transaction a clearing pass writes one row per cycle, and the pass ends
// before any result. The primes 2 and 3 need no memory access. A later
// transaction scans the candidates, reading each new memory row it touches
// into a row cache, squares the prime and compares the square with the
// limit, then marks each multiple composite with a read and a write of its
// row, and at last leaves the marking loop. The output register lets a new
// transaction start while a result still waits on out_stall.
module wheel_prime_sieve
  import wps_pkg::*;
#(
  parameter int SIEVE_SIZE = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_limit,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PRIME_W-1:0] out_prime,
  output logic               out_found
);

  localparam int CW = $clog2(SIEVE_SIZE + 1);

  logic [CFG_W-1:0]   limit_r;
  logic [CW-1:0]      lim_eff;
  seq_stat_t          stat;
  logic [PRIME_W-1:0] res_prime;
  logic               res_found;
  logic               res_take;
  logic               in_accept;
  logic               out_valid_r;
  logic [PRIME_W-1:0] out_prime_r;
  logic               out_found_r;

  assign cfg_ready = 1'b1;
  assign lim_eff   = (32'(limit_r) < 32'(SIEVE_SIZE)) ? CW'(limit_r) : CW'(SIEVE_SIZE);
  assign in_stall  = stat.busy;
  assign in_accept = in_valid && !in_stall;
  assign res_take  = stat.res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_limit;
    end
  end

  wps_seq #(
    .SIEVE_SIZE (SIEVE_SIZE),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_accept),
    .req_restart (in_restart),
    .lim_in      (lim_eff),
    .res_take    (res_take),
    .stat        (stat),
    .res_prime   (res_prime),
    .res_found   (res_found)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_prime_r <= res_prime;
      out_found_r <= res_found;
    end
  end

  assign out_valid = out_valid_r;
  assign out_prime = out_prime_r;
  assign out_found = out_found_r;

endmodule

// ===== rtl/core/wps_checker.sv =====
// Port-level checker for the wheel prime sieve and its bind to the top level.
module wps_checker
  import wps_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PRIME_W-1:0] out_prime,
  input logic               out_found
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime) && $stable(out_found))
    else $error("Stalled result transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken again before the previous transaction finished.");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_prime == '0)
    else $error("Result without a prime carries a nonzero value.");

  a_found_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_prime == PRIME_W'(2) ||
      (out_prime[0] && out_prime >= PRIME_W'(3)))
    else $error("Returned prime is neither two nor an odd value of three or more.");

endmodule

bind wheel_prime_sieve wps_checker u_wps_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the wheel prime sieve with a built-in prime sequence predictor.
module testbench;
  import wps_pkg::*;

  localparam int SIEVE_SIZE     = 65536;
  localparam int WHEEL_SHORT    = 2;
  localparam int WHEEL_LONG     = 4;
  localparam int FIRST_CAND     = 5;
  localparam int RANDOM_ITEMS   = 550;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [1:0] {LEAD_TWO, LEAD_THREE, SCANNING} lead_stage_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic               found;
  } prime_result_t;

  class sieve_scoreboard;
    bit            composite_map [SIEVE_SIZE];
    int unsigned   cursor;
    bit            step_two;
    lead_stage_t   stage;
    bit            exhausted;
    int unsigned   limit_reg;
    prime_result_t expected_primes [$];
    int unsigned   mismatches;

    function new();
      limit_reg  = 32'(LIMIT_RESET);
      mismatches = 0;
      clear_sieve();
    endfunction

    function void clear_sieve();
      foreach (composite_map[i]) composite_map[i] = 1'b0;
      cursor    = FIRST_CAND;
      step_two  = 1'b1;
      stage     = LEAD_TWO;
      exhausted = 1'b0;
    endfunction

    function void set_limit(input logic [CFG_W-1:0] value);
      limit_reg = 32'(value);
    endfunction

    function int unsigned pending();
      return expected_primes.size();
    endfunction

    function prime_result_t next_prime(input logic restart);
      prime_result_t   res;
      int unsigned     eff_limit;
      int unsigned     cand;
      longint unsigned mult;
      bit              phase;
      bit              alt;
      eff_limit = (limit_reg < SIEVE_SIZE) ? limit_reg : SIEVE_SIZE;
      res.prime = '0;
      res.found = 1'b0;
      if (restart) clear_sieve();
      case (stage)
        LEAD_TWO: begin
          res.prime = PRIME_W'(2);
          res.found = 1'b1;
          stage = LEAD_THREE;
        end
        LEAD_THREE: begin
          res.prime = PRIME_W'(3);
          res.found = 1'b1;
          stage = SCANNING;
        end
        default: begin
          if (!exhausted) begin
            while (!res.found && cursor < eff_limit) begin
              cand = cursor;
              phase = step_two;
              cursor += phase ? WHEEL_SHORT : WHEEL_LONG;
              step_two = !phase;
              if (!composite_map[16'(cand)]) begin
                mult = longint'(cand) * cand;
                alt = phase;
                while (mult < eff_limit) begin
                  composite_map[16'(mult)] = 1'b1;
                  mult += longint'(cand) * (alt ? WHEEL_SHORT : WHEEL_LONG);
                  alt = !alt;
                end
                res.prime = cand[PRIME_W-1:0];
                res.found = 1'b1;
              end
            end
            if (!res.found) exhausted = 1'b1;
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(input logic restart);
      expected_primes = {expected_primes, next_prime(restart)};
    endfunction

    function void check_result(input logic [PRIME_W-1:0] got_prime, input logic got_found);
      prime_result_t want;
      if (expected_primes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: prime %0d found %0b", got_prime, got_found);
        mismatches++;
        return;
      end
      want = expected_primes.pop_front();
      if (want.prime !== got_prime || want.found !== got_found) begin
        if (mismatches < MAX_REPORTS)
          $display("mismatch: expected prime %0d found %0b, got prime %0d found %0b",
                   want.prime, want.found, got_prime, got_found);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_limit;
  logic               in_valid;
  logic               in_stall;
  logic               in_restart;
  logic               out_valid;
  logic               out_stall;
  logic [PRIME_W-1:0] out_prime;
  logic               out_found;

  sieve_scoreboard sb;
  bit              hold_pending;
  bit              quiet;
  int unsigned     items_sent;

  wheel_prime_sieve #(
    .SIEVE_SIZE(SIEVE_SIZE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_limit (cfg_limit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_restart(in_restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_prime (out_prime),
    .out_found (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_restart);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_prime, out_found);
  end

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                    (cfg_valid && cfg_ready)))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic restart);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_phase(input bit do_write, input logic [CFG_W-1:0] lim,
                           input int unsigned count, input logic [63:0] restart_mask);
    wait_drained();
    if (do_write) write_limit(lim);
    for (int i = 0; i < count; i++) send_request(restart_mask[i]);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned      phase_idx;
    int unsigned      pick;
    int unsigned      count;
    logic [CFG_W-1:0] lim;
    logic [63:0]      mask;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_limit  <= '0;
    hold_pending = 1'b0;
    quiet        = 1'b0;
    items_sent   = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(1'b0, '0, 4, 64'b0);
    run_phase(1'b0, '0, 3, 64'b011);
    run_phase(1'b1, 17'd0, 4, 64'b0010);
    run_phase(1'b1, 17'd5, 3, 64'b001);
    run_phase(1'b1, 17'd8, 5, 64'b00001);
    run_phase(1'b1, 17'd30, 2, 64'b10);
    run_phase(1'b1, 17'd131071, 3, 64'b0);

    phase_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        lim = CFG_W'($urandom_range(0, 5));
        count = $urandom_range(4, 10);
      end else if (pick < 10) begin
        lim = ($urandom_range(1) != 0) ? 17'd65536 : CFG_W'($urandom_range(65537, 131071));
        count = $urandom_range(2, 5);
      end else if (pick < 70) begin
        lim = CFG_W'($urandom_range(6, 300));
        count = $urandom_range(10, 40);
      end else begin
        lim = CFG_W'($urandom_range(301, 4000));
        count = $urandom_range(10, 40);
      end
      mask = '0;
      for (int i = 0; i < count; i++)
        mask[i] = (i == 0) ? ($urandom_range(1) != 0) : ($urandom_range(99) < 6);
      wait_drained();
      quiet = (phase_idx == 5);
      if (phase_idx == 2) begin
        hold_pending = 1'b1;
        count = 40;
      end
      run_phase(1'b1, lim, count, mask);
      phase_idx++;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/wps_pkg.sv
rtl/core/wps_mem.sv
rtl/core/wps_seq.sv
rtl/core/wheel_prime_sieve.sv
rtl/core/wps_checker.sv
dv/testbench.sv
